// File: src/mcal_pkg.sv
// Shared types, codes and constants for the magnetometer calibration block.
// Depends on nothing; used by mag_calibrate_heading and its testbench.
package mcal_pkg;

  localparam int RAW_W        = 16;
  localparam int CAL_W        = 20;
  localparam int HEADING_W    = 15;
  localparam int GAIN_W       = 16;
  localparam int CENTRE_W     = 17;
  localparam int ANGLE_FRAC   = 16;
  localparam int ANGLE_W      = 27;
  localparam int ROT_W        = 32;

  localparam int DEF_CORDIC_STEPS      = 16;
  localparam int DEF_HEADING_FRAC_BITS = 6;
  localparam int DEF_GAIN_FRAC_BITS    = 14;

  typedef enum logic [1:0] {
    REQ_MEASURE = 2'd0,
    REQ_SAMPLE  = 2'd1,
    REQ_FINISH  = 2'd2,
    REQ_SPARE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_MEASURED = 2'd0,
    STAT_TRACKED  = 2'd1,
    STAT_CAL_DONE = 2'd2,
    STAT_CAL_FAIL = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_MUL_START,
    ST_MUL_RUN,
    ST_MUL_END,
    ST_ROT_START,
    ST_ROT_RUN,
    ST_ROT_END,
    ST_DONE
  } state_t;

  function automatic logic [21:0] atan_step(input logic [4:0] idx);
    logic [21:0] a;
    case (idx)
      5'd0:  a = 22'd2949120;
      5'd1:  a = 22'd1740967;
      5'd2:  a = 22'd919879;
      5'd3:  a = 22'd466945;
      5'd4:  a = 22'd234379;
      5'd5:  a = 22'd117304;
      5'd6:  a = 22'd58666;
      5'd7:  a = 22'd29335;
      5'd8:  a = 22'd14668;
      5'd9:  a = 22'd7334;
      5'd10: a = 22'd3667;
      5'd11: a = 22'd1833;
      5'd12: a = 22'd917;
      5'd13: a = 22'd458;
      5'd14: a = 22'd229;
      5'd15: a = 22'd115;
      5'd16: a = 22'd57;
      5'd17: a = 22'd29;
      5'd18: a = 22'd14;
      5'd19: a = 22'd7;
      5'd20: a = 22'd4;
      5'd21: a = 22'd2;
      5'd22: a = 22'd1;
      default: a = 22'd0;
    endcase
    return a;
  endfunction

endpackage

// File: src/mcal_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing outside this file.
module mcal_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 18
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] q;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem, q[NUM_W-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = trial >= {1'b0, den};
  assign quo   = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q   <= num;
    end else if (busy) begin
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      q   <= {q[NUM_W-2:0], ge};
    end
  end

endmodule

// File: src/mag_calibrate_heading.sv
// One transfer at a time, set by the serial multiplier and divider; a successful
// finish request also runs the three gain divisions (one quotient bit per cycle).
// A finished result waits in the output register while the next item is taken.
// Reset (rst, synchronous): trackers cleared, centre 0, unit gain, not calibrated.
// Top level; depends on mcal_pkg and mcal_div.
module mag_calibrate_heading #(
  parameter int CORDIC_STEPS      = mcal_pkg::DEF_CORDIC_STEPS,
  parameter int HEADING_FRAC_BITS = mcal_pkg::DEF_HEADING_FRAC_BITS,
  parameter int GAIN_FRAC_BITS    = mcal_pkg::DEF_GAIN_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          req_type,
  input  logic signed [mcal_pkg::RAW_W-1:0]   raw_x,
  input  logic signed [mcal_pkg::RAW_W-1:0]   raw_y,
  input  logic signed [mcal_pkg::RAW_W-1:0]   raw_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mcal_pkg::HEADING_W-1:0]      heading,
  output logic signed [mcal_pkg::CAL_W-1:0]   cal_x,
  output logic signed [mcal_pkg::CAL_W-1:0]   cal_y,
  output logic signed [mcal_pkg::CAL_W-1:0]   cal_z,
  output logic [1:0]                          status,
  output logic                                calibrated
);
  import mcal_pkg::*;

  localparam int GF      = GAIN_FRAC_BITS;
  localparam int SUM_W   = RAW_W + 2;
  localparam int DEN_W   = RAW_W + 2;
  localparam int NUM_W   = SUM_W + GF;
  localparam int D_W     = RAW_W + 2;
  localparam int P_W     = D_W + GAIN_W + 1;
  localparam int MC_W    = $clog2(GAIN_W + 1);
  localparam int STEP_W  = $clog2(CORDIC_STEPS + 1);
  localparam int SH      = ANGLE_FRAC - HEADING_FRAC_BITS;
  localparam int UNIT_G  = (GF >= GAIN_W) ? 65535 : (1 << GF);
  localparam logic signed [ANGLE_W-1:0] DEG180 = ANGLE_W'(180 << ANGLE_FRAC);
  localparam logic signed [ANGLE_W-1:0] DEG360 = ANGLE_W'(360 << ANGLE_FRAC);
  localparam logic [ANGLE_W-1:0] HFULL = ANGLE_W'(360 << HEADING_FRAC_BITS);
  localparam logic signed [P_W-1:0] CAL_HI = P_W'(524287);
  localparam logic signed [P_W-1:0] CAL_LO = -P_W'(524288);

  state_t state, state_next;

  req_t                       req;
  logic signed [RAW_W-1:0]    rx, ry, rz;
  logic signed [RAW_W-1:0]    low_x, low_y, low_z, high_x, high_y, high_z;
  logic signed [CENTRE_W-1:0] centre_x, centre_y, centre_z;
  logic [GAIN_W-1:0]          gain_x, gain_y, gain_z;
  logic                       cal_valid, any_sample;
  logic [RAW_W-1:0]           rng_x, rng_y, rng_z;
  logic [SUM_W-1:0]           rng_sum;
  logic [1:0]                 axis;
  status_t                    stat;

  logic signed [CAL_W-1:0]    cx, cy, cz;
  logic signed [D_W-1:0]      mul_d;
  logic [GAIN_W-1:0]          mul_g;
  logic signed [P_W-1:0]      acc;
  logic [MC_W-1:0]            mul_cnt;

  logic signed [ROT_W-1:0]    rot_x, rot_y;
  logic signed [ANGLE_W-1:0]  rot_z;
  logic [STEP_W-1:0]          step;
  logic                       zero_vec;

  logic signed [RAW_W:0]      dx, dy, dz;
  logic                       fin_fail;
  logic [RAW_W-1:0]           div_r;
  logic [DEN_W-1:0]           div_den;
  logic [NUM_W-1:0]           div_num;
  logic [NUM_W-1:0]           div_quo;
  logic                       div_done;
  logic [GAIN_W-1:0]          gain_new;
  logic signed [RAW_W-1:0]    sel_raw;
  logic signed [CENTRE_W-1:0] sel_centre;
  logic [GAIN_W-1:0]          sel_gain;
  logic signed [P_W-1:0]      p_round;
  logic signed [P_W-1:0]      p_shift;
  logic signed [CAL_W-1:0]    p_sat;
  logic signed [ROT_W-1:0]    xs, ys;
  logic signed [ANGLE_W-1:0]  z_wrap;
  logic [ANGLE_W-1:0]         h_raw;
  logic [ANGLE_W-1:0]         h_fix;
  logic                       out_load;

  assign dx = {high_x[RAW_W-1], high_x} - {low_x[RAW_W-1], low_x};
  assign dy = {high_y[RAW_W-1], high_y} - {low_y[RAW_W-1], low_y};
  assign dz = {high_z[RAW_W-1], high_z} - {low_z[RAW_W-1], low_z};
  assign fin_fail = !any_sample || dx <= 0 || dy <= 0 || dz <= 0;

  always_comb begin
    case (axis)
      2'd0:    div_r = rng_x;
      2'd1:    div_r = rng_y;
      default: div_r = rng_z;
    endcase
  end
  assign div_den = {2'b00, div_r} + {1'b0, div_r, 1'b0};
  assign div_num = {rng_sum, {GF{1'b0}}} + NUM_W'(div_den >> 1);
  assign gain_new = (div_quo > NUM_W'(65535)) ? GAIN_W'(65535) : div_quo[GAIN_W-1:0];

  always_comb begin
    case (axis)
      2'd0: begin
        sel_raw = rx; sel_centre = centre_x; sel_gain = gain_x;
      end
      2'd1: begin
        sel_raw = ry; sel_centre = centre_y; sel_gain = gain_y;
      end
      default: begin
        sel_raw = rz; sel_centre = centre_z; sel_gain = gain_z;
      end
    endcase
  end

  assign p_round = acc + (P_W'(1) <<< (GF - 2));
  assign p_shift = p_round >>> (GF - 1);
  assign p_sat = (p_shift > CAL_HI) ? CAL_W'(524287) :
                 (p_shift < CAL_LO) ? -CAL_W'(524288) : p_shift[CAL_W-1:0];

  assign xs = rot_x >>> step;
  assign ys = rot_y >>> step;

  assign z_wrap = rot_z[ANGLE_W-1] ? rot_z + DEG360 : rot_z;
  assign h_raw = (ANGLE_W'(z_wrap) + (ANGLE_W'(1) << (SH - 1))) >> SH;
  assign h_fix = (h_raw >= HFULL) ? h_raw - HFULL : h_raw;

  assign in_stall = state != ST_IDLE;
  assign out_load = state == ST_DONE && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_PREP;
      end
      ST_PREP: begin
        if (req == REQ_FINISH && !fin_fail) state_next = ST_DIV_START;
        else state_next = ST_MUL_START;
      end
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) state_next = (axis == 2'd2) ? ST_MUL_START : ST_DIV_START;
      end
      ST_MUL_START: state_next = ST_MUL_RUN;
      ST_MUL_RUN: begin
        if (mul_cnt == MC_W'(1)) state_next = ST_MUL_END;
      end
      ST_MUL_END: state_next = (axis == 2'd2) ? ST_ROT_START : ST_MUL_START;
      ST_ROT_START: state_next = ST_ROT_RUN;
      ST_ROT_RUN: begin
        if (step == STEP_W'(CORDIC_STEPS - 1)) state_next = ST_ROT_END;
      end
      ST_ROT_END: state_next = ST_DONE;
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_x <= RAW_W'(32767); low_y <= RAW_W'(32767); low_z <= RAW_W'(32767);
      high_x <= -RAW_W'(32768); high_y <= -RAW_W'(32768); high_z <= -RAW_W'(32768);
      centre_x <= '0; centre_y <= '0; centre_z <= '0;
      gain_x <= GAIN_W'(UNIT_G); gain_y <= GAIN_W'(UNIT_G); gain_z <= GAIN_W'(UNIT_G);
      cal_valid <= 1'b0;
      any_sample <= 1'b0;
    end else if (state == ST_PREP) begin
      if (req == REQ_SAMPLE) begin
        if (rx < low_x) low_x <= rx;
        if (rx > high_x) high_x <= rx;
        if (ry < low_y) low_y <= ry;
        if (ry > high_y) high_y <= ry;
        if (rz < low_z) low_z <= rz;
        if (rz > high_z) high_z <= rz;
        any_sample <= 1'b1;
      end else if (req == REQ_FINISH) begin
        if (!fin_fail) begin
          centre_x <= {low_x[RAW_W-1], low_x} + {high_x[RAW_W-1], high_x};
          centre_y <= {low_y[RAW_W-1], low_y} + {high_y[RAW_W-1], high_y};
          centre_z <= {low_z[RAW_W-1], low_z} + {high_z[RAW_W-1], high_z};
          cal_valid <= 1'b1;
        end
        low_x <= RAW_W'(32767); low_y <= RAW_W'(32767); low_z <= RAW_W'(32767);
        high_x <= -RAW_W'(32768); high_y <= -RAW_W'(32768); high_z <= -RAW_W'(32768);
        any_sample <= 1'b0;
      end
    end else if (state == ST_DIV_WAIT && div_done) begin
      case (axis)
        2'd0:    gain_x <= gain_new;
        2'd1:    gain_y <= gain_new;
        default: gain_z <= gain_new;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          req <= req_t'(req_type);
          rx <= raw_x; ry <= raw_y; rz <= raw_z;
        end
        axis <= 2'd0;
      end
      ST_PREP: begin
        rng_x <= dx[RAW_W-1:0];
        rng_y <= dy[RAW_W-1:0];
        rng_z <= dz[RAW_W-1:0];
        rng_sum <= SUM_W'(dx[RAW_W-1:0]) + SUM_W'(dy[RAW_W-1:0]) + SUM_W'(dz[RAW_W-1:0]);
        case (req)
          REQ_SAMPLE: stat <= STAT_TRACKED;
          REQ_FINISH: stat <= fin_fail ? STAT_CAL_FAIL : STAT_CAL_DONE;
          default:    stat <= STAT_MEASURED;
        endcase
      end
      ST_DIV_WAIT: begin
        if (div_done) axis <= (axis == 2'd2) ? 2'd0 : axis + 2'd1;
      end
      ST_MUL_START: begin
        mul_d <= {sel_raw[RAW_W-1], sel_raw, 1'b0} - {sel_centre[CENTRE_W-1], sel_centre};
        mul_g <= sel_gain;
        acc <= '0;
        mul_cnt <= MC_W'(GAIN_W);
      end
      ST_MUL_RUN: begin
        acc <= (acc <<< 1) + (mul_g[GAIN_W-1] ? P_W'(mul_d) : P_W'(0));
        mul_g <= {mul_g[GAIN_W-2:0], 1'b0};
        mul_cnt <= mul_cnt - 1'b1;
      end
      ST_MUL_END: begin
        case (axis)
          2'd0:    cx <= p_sat;
          2'd1:    cy <= p_sat;
          default: cz <= p_sat;
        endcase
        axis <= (axis == 2'd2) ? 2'd0 : axis + 2'd1;
      end
      ST_ROT_START: begin
        zero_vec <= cx == '0 && cy == '0;
        step <= '0;
        if (cx[CAL_W-1]) begin
          rot_x <= -(ROT_W'(cx) <<< 8);
          rot_y <= -(ROT_W'(cy) <<< 8);
          rot_z <= DEG180;
        end else begin
          rot_x <= ROT_W'(cx) <<< 8;
          rot_y <= ROT_W'(cy) <<< 8;
          rot_z <= '0;
        end
      end
      ST_ROT_RUN: begin
        step <= step + 1'b1;
        if (!rot_y[ROT_W-1]) begin
          rot_x <= rot_x + ys;
          rot_y <= rot_y - xs;
          rot_z <= rot_z + ANGLE_W'(atan_step(5'(step)));
        end else begin
          rot_x <= rot_x - ys;
          rot_y <= rot_y + xs;
          rot_z <= rot_z - ANGLE_W'(atan_step(5'(step)));
        end
      end
      ST_ROT_END: begin
        rot_z <= zero_vec ? '0 : signed'(h_fix);
      end
      default: begin
      end
    endcase
  end

  mcal_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(state == ST_DIV_START),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      heading    <= rot_z[HEADING_W-1:0];
      cal_x      <= cx;
      cal_y      <= cy;
      cal_z      <= cz;
      status     <= stat;
      calibrated <= cal_valid;
    end
  end

`ifndef NO_ASSERTIONS
  a_cal_sticky: assert property (@(posedge clk) disable iff (rst) !$fell(cal_valid))
    else $error("calibration flag dropped");
  a_gain_nonzero: assert property (@(posedge clk) disable iff (rst)
    gain_x != '0 && gain_y != '0 && gain_z != '0)
    else $error("gain reached zero");
  a_done_flag: assert property (@(posedge clk) disable iff (rst)
    out_load && stat == STAT_CAL_DONE |=> calibrated)
    else $error("calibration done without calibrated flag");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> !$past(out_load))
    else $error("output overwritten while stalled");
`endif

endmodule

// File: tb/sv/tb_mag_calibrate_heading.sv
// Self-checking testbench for mag_calibrate_heading: random and directed requests,
// each result checked against a behavioral predictor of calibration and heading.
// Depends on mcal_pkg and the block under test.
module tb_mag_calibrate_heading;
  import mcal_pkg::*;

  typedef struct packed {
    logic [1:0]  req;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
  } req_item_t;

  typedef struct packed {
    logic [14:0] hdg;
    logic [19:0] cx;
    logic [19:0] cy;
    logic [19:0] cz;
    logic [1:0]  st;
    logic        calv;
  } cal_result_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] req_type = 0;
  logic signed [15:0] raw_x = 0, raw_y = 0, raw_z = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [14:0] heading;
  logic signed [19:0] cal_x, cal_y, cal_z;
  logic [1:0] status;
  logic calibrated;

  mag_calibrate_heading dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .raw_x(raw_x), .raw_y(raw_y), .raw_z(raw_z),
    .out_valid(out_valid), .out_stall(out_stall), .heading(heading),
    .cal_x(cal_x), .cal_y(cal_y), .cal_z(cal_z), .status(status),
    .calibrated(calibrated)
  );

  req_item_t   pending_reqs[$];
  cal_result_t expected_results[$];
  int errors = 0;
  int send_idle_pct = 12;
  int recv_idle_pct = 57;
  bit hold_send = 0;
  longint cycles = 0;

  longint lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
  longint ctr_x, ctr_y, ctr_z;
  longint gn_x, gn_y, gn_z;
  bit cal_ok, seen_any;

  longint atan_tab[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                           29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

  function automatic void clear_minmax();
    lo_x = 32767; lo_y = 32767; lo_z = 32767;
    hi_x = -32768; hi_y = -32768; hi_z = -32768;
    seen_any = 0;
  endfunction

  function automatic longint calibrate_axis(longint r, longint c, longint g);
    longint q;
    q = ((2 * r - c) * g + 4096) >>> 13;
    if (q > 524287) q = 524287;
    if (q < -524288) q = -524288;
    return q;
  endfunction

  function automatic longint derive_gain(longint s, longint r);
    longint g;
    g = ((s << 14) + (3 * r) / 2) / (3 * r);
    return g > 65535 ? 65535 : g;
  endfunction

  function automatic longint heading_from(longint cx, longint cy);
    longint x, y, z, xn, h;
    x = cx * 256; y = cy * 256; z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      x = -x; y = -y; z = 180 << 16;
    end
    for (int i = 0; i < 16; i++) begin
      if (y >= 0) begin
        xn = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
      end else begin
        xn = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
      end
      x = xn;
    end
    while (z < 0) z += 360 << 16;
    while (z >= (360 << 16)) z -= 360 << 16;
    h = (z + 512) >> 10;
    if (h >= 360 * 64) h -= 360 * 64;
    return h;
  endfunction

  function automatic cal_result_t predict_heading(req_item_t it);
    cal_result_t r;
    longint rx, ry, rz, ax, ay, az, cx, cy, cz;
    rx = longint'($signed(it.x)); ry = longint'($signed(it.y));
    rz = longint'($signed(it.z));
    r.st = STAT_MEASURED;
    if (it.req == REQ_SAMPLE) begin
      if (rx < lo_x) lo_x = rx; if (rx > hi_x) hi_x = rx;
      if (ry < lo_y) lo_y = ry; if (ry > hi_y) hi_y = ry;
      if (rz < lo_z) lo_z = rz; if (rz > hi_z) hi_z = rz;
      seen_any = 1;
      r.st = STAT_TRACKED;
    end else if (it.req == REQ_FINISH) begin
      ax = hi_x - lo_x; ay = hi_y - lo_y; az = hi_z - lo_z;
      if (!seen_any || ax <= 0 || ay <= 0 || az <= 0) begin
        r.st = STAT_CAL_FAIL;
      end else begin
        ctr_x = lo_x + hi_x; ctr_y = lo_y + hi_y; ctr_z = lo_z + hi_z;
        gn_x = derive_gain(ax + ay + az, ax);
        gn_y = derive_gain(ax + ay + az, ay);
        gn_z = derive_gain(ax + ay + az, az);
        cal_ok = 1;
        r.st = STAT_CAL_DONE;
      end
      clear_minmax();
    end
    cx = calibrate_axis(rx, ctr_x, gn_x);
    cy = calibrate_axis(ry, ctr_y, gn_y);
    cz = calibrate_axis(rz, ctr_z, gn_z);
    r.hdg = 15'(heading_from(cx, cy));
    r.cx = cx[19:0]; r.cy = cy[19:0]; r.cz = cz[19:0];
    r.calv = cal_ok;
    return r;
  endfunction

  function automatic logic [15:0] rand_raw(int mode);
    case (mode)
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 8000) - 4000);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void push_req(logic [1:0] rq, logic [15:0] x, logic [15:0] y,
                                   logic [15:0] z);
    req_item_t it;
    it.req = rq; it.x = x; it.y = y; it.z = z;
    pending_reqs.push_back(it);
  endfunction

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_heading('{req_type, raw_x, raw_y, raw_z}));
        pending_reqs.pop_front();
      end
      if (!(in_valid && in_stall)) begin
        if (pending_reqs.size() > 0 && !hold_send &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1;
          req_type <= pending_reqs[0].req;
          raw_x <= pending_reqs[0].x;
          raw_y <= pending_reqs[0].y;
          raw_z <= pending_reqs[0].z;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    cal_result_t got, want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = '{heading, cal_x, cal_y, cal_z, status, calibrated};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.hdg !== want.hdg)
            $display("%0t: heading exp %0d got %0d", $time, want.hdg, got.hdg);
          if (got.cx !== want.cx)
            $display("%0t: cal_x exp %0d got %0d", $time, want.cx, got.cx);
          if (got.cy !== want.cy)
            $display("%0t: cal_y exp %0d got %0d", $time, want.cy, got.cy);
          if (got.cz !== want.cz)
            $display("%0t: cal_z exp %0d got %0d", $time, want.cz, got.cz);
          if (got.st !== want.st)
            $display("%0t: status exp %0d got %0d", $time, want.st, got.st);
          if (got.calv !== want.calv)
            $display("%0t: calibrated exp %0d got %0d", $time, want.calv, got.calv);
          if (got !== want) errors++;
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int n, mode;
    clear_minmax();
    ctr_x = 0; ctr_y = 0; ctr_z = 0;
    gn_x = 16384; gn_y = 16384; gn_z = 16384;
    cal_ok = 0;
    repeat (4) @(posedge clk);
    rst <= 0;

    push_req(REQ_MEASURE, 16'h0000, 16'h0000, 16'h0000);
    push_req(REQ_MEASURE, 16'h7fff, 16'h8000, 16'h7fff);
    push_req(REQ_MEASURE, 16'h8000, 16'h0000, 16'h8000);
    push_req(REQ_MEASURE, 16'h0000, 16'h8000, 16'h0001);
    push_req(REQ_MEASURE, 16'h8000, 16'hffff, 16'h0000);
    push_req(REQ_SPARE, 16'h1234, 16'hfedc, 16'h5555);
    push_req(REQ_FINISH, 16'h0100, 16'h0200, 16'h0300);
    push_req(REQ_SAMPLE, 16'h0010, 16'h0010, 16'h0010);
    push_req(REQ_FINISH, 16'h0010, 16'h0010, 16'h0010);
    push_req(REQ_SAMPLE, 16'h8000, 16'h8000, 16'h8000);
    push_req(REQ_SAMPLE, 16'h7fff, 16'h7fff, 16'h7fff);
    push_req(REQ_FINISH, 16'h7fff, 16'h8000, 16'h0000);
    push_req(REQ_MEASURE, 16'h7fff, 16'h8000, 16'h0000);
    push_req(REQ_SAMPLE, 16'hfff0, 16'h0000, 16'h0100);
    push_req(REQ_SAMPLE, 16'h0010, 16'h0001, 16'h0101);
    push_req(REQ_FINISH, 16'h8000, 16'h7fff, 16'h8000);
    push_req(REQ_MEASURE, 16'h8000, 16'h8000, 16'h7fff);
    wait_drained();

    hold_send = 1;
    repeat (150) @(posedge clk);
    hold_send = 0;

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 12 : (phase == 1 ? 57 : 0);
      recv_idle_pct = phase == 0 ? 57 : (phase == 1 ? 12 : 0);
      for (int k = 0; k < 650; ) begin
        if ($urandom_range(0, 9) < 7) begin
          n = $urandom_range(1, 12);
          mode = $urandom_range(0, 9) == 0 ? 3 : $urandom_range(2, 3);
          for (int j = 0; j < n; j++)
            push_req(REQ_SAMPLE, rand_raw(mode), rand_raw(mode), rand_raw(mode));
          if ($urandom_range(0, 7) == 0)
            push_req(REQ_SAMPLE, rand_raw($urandom_range(0, 1)),
                     rand_raw($urandom_range(0, 1)), rand_raw($urandom_range(0, 1)));
          push_req(REQ_FINISH, rand_raw(3), rand_raw(3), rand_raw(3));
          repeat ($urandom_range(1, 4))
            push_req($urandom_range(0, 9) == 0 ? REQ_SPARE : REQ_MEASURE,
                     rand_raw($urandom_range(0, 3)), rand_raw($urandom_range(0, 3)),
                     rand_raw($urandom_range(0, 3)));
          k += n + 4;
        end else begin
          push_req(2'($urandom_range(0, 3)), rand_raw($urandom_range(0, 3)),
                   rand_raw($urandom_range(0, 3)), rand_raw($urandom_range(0, 3)));
          k++;
        end
        while (pending_reqs.size() >= 20)
          @(posedge clk);
      end
      wait_drained();
    end

    repeat (300) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// File: files.f
src/mcal_pkg.sv
src/mcal_div.sv
src/mag_calibrate_heading.sv
tb/sv/tb_mag_calibrate_heading.sv
